// ===== rtl/core/ksc_pkg.sv =====
// Shared types, constants and letter decoding for the keyword substitution cipher.
`default_nettype none
package ksc_pkg;

   localparam int LETTERS = 26;
   localparam logic [4:0] LAST_LETTER = 5'd25;

   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;

   // Register reset values; the keyword spells FEATHER.
   localparam logic [63:0] KEY_RESET = 64'd23157125043799366;
   localparam logic [3:0]  LEN_RESET = 4'd7;

   // Register indexes on the csr port.
   localparam logic [1:0] CSR_KEYWORD = 2'd0;
   localparam logic [1:0] CSR_LENGTH  = 2'd1;
   localparam logic [1:0] CSR_MODE    = 2'd2;

   typedef enum logic [1:0] {
      BLD_CLEAR,
      BLD_KEY,
      BLD_FILL,
      BLD_DONE
   } build_state_type;

   typedef struct packed {
      logic       is_letter;
      logic [4:0] idx;
   } letter_info_type;

   typedef struct packed {
      logic       en;
      logic [4:0] addr;
      logic [4:0] data;
   } tbl_wr_type;

   // Letter number 0..25 of an ASCII letter; idx is zero for any other byte.
   function automatic letter_info_type letter_decode(input logic [7:0] b);
      letter_info_type r;
      r.is_letter = 1'b0;
      r.idx       = 5'd0;
      if (b >= CH_UPPER_A && b <= CH_UPPER_Z) begin
         r.is_letter = 1'b1;
         r.idx       = 5'(b - CH_UPPER_A);
      end else if (b >= CH_LOWER_A && b <= CH_LOWER_Z) begin
         r.is_letter = 1'b1;
         r.idx       = 5'(b - CH_LOWER_A);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/keyword_substitution_cipher.sv =====
// The result of a byte accepted at one clock edge shows on rsp in the next cycle.
// Throughput: one byte per cycle once the table is built; the output register
// frees the input side as soon as the waiting word is taken.
// After reset and after each write to the keyword, length or mode register, the
// builder walks min(keyword_length, MAX_KEY_CHARS) key bytes, then the rest, and
// req_stall stays high until it finishes. Reset is synchronous, active high.
`default_nettype none
module keyword_substitution_cipher #(
   parameter int MAX_KEY_CHARS = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_byte,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_wdata
);

   localparam int KEY_W = 8 * MAX_KEY_CHARS;

   logic [KEY_W-1:0] keyword_ff, keyword_in;
   logic [3:0]       key_len_ff, key_len_in;
   logic             decrypt_ff, decrypt_in;
   logic             cfg_hit;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_byte_ff, rsp_byte_in;

   logic [4:0]       tbl_ff [ksc_pkg::LETTERS];

   ksc_pkg::tbl_wr_type      tbl_wr;
   ksc_pkg::letter_info_type in_info;
   logic             build_done;
   logic             accept;
   logic [4:0]       mapped;

   assign csr_ready = 1'b1;

   always_comb begin
      keyword_in = keyword_ff;
      key_len_in = key_len_ff;
      decrypt_in = decrypt_ff;
      cfg_hit    = 1'b0;
      if (csr_valid) begin
         unique case (csr_index)
            ksc_pkg::CSR_KEYWORD: begin
               keyword_in = csr_wdata[KEY_W-1:0];
               cfg_hit    = 1'b1;
            end
            ksc_pkg::CSR_LENGTH: begin
               key_len_in = csr_wdata[3:0];
               cfg_hit    = 1'b1;
            end
            ksc_pkg::CSR_MODE: begin
               decrypt_in = csr_wdata[0];
               cfg_hit    = 1'b1;
            end
            default: begin
               cfg_hit = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keyword_ff   <= ksc_pkg::KEY_RESET[KEY_W-1:0];
         key_len_ff   <= ksc_pkg::LEN_RESET;
         decrypt_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         keyword_ff   <= keyword_in;
         key_len_ff   <= key_len_in;
         decrypt_ff   <= decrypt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   ksc_build #(
      .MAX_KEY_CHARS(MAX_KEY_CHARS)
   ) u_build (
      .clock   (clock),
      .reset   (reset),
      .restart (cfg_hit),
      .keyword (keyword_ff),
      .key_len (key_len_ff),
      .decrypt (decrypt_ff),
      .tbl_wr  (tbl_wr),
      .done    (build_done)
   );

   // Every entry is written by the builder before the first byte is taken.
   always_ff @(posedge clock) begin
      if (tbl_wr.en) begin
         tbl_ff[tbl_wr.addr] <= tbl_wr.data;
      end
   end

   assign req_stall = !build_done || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   assign in_info = ksc_pkg::letter_decode(req_data_byte);
   assign mapped  = tbl_ff[in_info.idx];

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_byte_in  = rsp_byte_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         if (!in_info.is_letter) begin
            rsp_byte_in = req_data_byte;
         end else if (req_data_byte >= ksc_pkg::CH_LOWER_A) begin
            rsp_byte_in = ksc_pkg::CH_LOWER_A + 8'(mapped);
         end else begin
            rsp_byte_in = ksc_pkg::CH_UPPER_A + 8'(mapped);
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;

   a_no_accept_before_build: assert property (@(posedge clock) disable iff (reset)
      accept |-> build_done)
      else $error("byte accepted before the table was built");

   a_cfg_restarts_build: assert property (@(posedge clock) disable iff (reset)
      cfg_hit |=> !build_done)
      else $error("register write did not restart the table build");

   a_accept_gives_word: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted byte produced no result word");

   a_passthrough: assert property (@(posedge clock) disable iff (reset)
      accept && !in_info.is_letter |=> rsp_out_byte == $past(req_data_byte))
      else $error("non-letter byte was altered");

   a_no_write_when_done: assert property (@(posedge clock) disable iff (reset)
      build_done |-> !tbl_wr.en)
      else $error("table written after build finished");

endmodule
`default_nettype wire

// ===== rtl/core/ksc_build.sv =====
// Sequencer that builds the cipher table from the keyword, then the letters left out.
`default_nettype none
module ksc_build #(
   parameter int MAX_KEY_CHARS = 8
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       restart,
   input  wire logic [8*MAX_KEY_CHARS-1:0] keyword,
   input  wire logic [3:0]                 key_len,
   input  wire logic                       decrypt,
   output ksc_pkg::tbl_wr_type             tbl_wr,
   output logic                            done
);

   localparam int KIDX_W = (MAX_KEY_CHARS > 1) ? $clog2(MAX_KEY_CHARS) : 1;

   ksc_pkg::build_state_type state_ff, state_in;
   logic [3:0]  key_pos_ff, key_pos_in;
   logic [4:0]  letter_ff, letter_in;
   logic [4:0]  fill_n_ff, fill_n_in;
   logic [25:0] used_ff, used_in;

   logic [7:0]  key_bytes [MAX_KEY_CHARS];
   logic [3:0]  len_clamped;
   ksc_pkg::letter_info_type key_info;
   logic        take;
   logic [4:0]  cand;

   always_comb begin
      for (int i = 0; i < MAX_KEY_CHARS; i++) begin
         key_bytes[i] = keyword[8*i +: 8];
      end
   end

   assign len_clamped = (key_len > 4'(MAX_KEY_CHARS)) ? 4'(MAX_KEY_CHARS) : key_len;
   assign key_info    = ksc_pkg::letter_decode(key_bytes[key_pos_ff[KIDX_W-1:0]]);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ksc_pkg::BLD_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      key_pos_ff <= key_pos_in;
      letter_ff  <= letter_in;
      fill_n_ff  <= fill_n_in;
      used_ff    <= used_in;
   end

   always_comb begin
      state_in   = state_ff;
      key_pos_in = key_pos_ff;
      letter_in  = letter_ff;
      fill_n_in  = fill_n_ff;
      used_in    = used_ff;
      take       = 1'b0;
      cand       = letter_ff;
      done       = 1'b0;

      unique case (state_ff)
         ksc_pkg::BLD_CLEAR: begin
            used_in    = '0;
            fill_n_in  = '0;
            key_pos_in = '0;
            state_in   = ksc_pkg::BLD_KEY;
         end
         ksc_pkg::BLD_KEY: begin
            cand = key_info.idx;
            if (key_pos_ff == len_clamped) begin
               letter_in = ksc_pkg::LAST_LETTER;
               state_in  = ksc_pkg::BLD_FILL;
            end else begin
               key_pos_in = key_pos_ff + 4'd1;
               take       = key_info.is_letter && !used_ff[key_info.idx];
            end
         end
         ksc_pkg::BLD_FILL: begin
            // Letters the keyword left out follow from Z down to A.
            take = !used_ff[letter_ff];
            if (letter_ff == 5'd0) begin
               state_in = ksc_pkg::BLD_DONE;
            end else begin
               letter_in = letter_ff - 5'd1;
            end
         end
         ksc_pkg::BLD_DONE: begin
            done = 1'b1;
         end
         default: begin
            state_in = ksc_pkg::BLD_CLEAR;
         end
      endcase

      if (take) begin
         used_in[cand] = 1'b1;
         fill_n_in     = fill_n_ff + 5'd1;
      end

      if (restart) begin
         state_in = ksc_pkg::BLD_CLEAR;
      end
   end

   // The decrypt table is the inverse map: the letter points back to its position.
   assign tbl_wr.en   = take;
   assign tbl_wr.addr = decrypt ? cand : fill_n_ff;
   assign tbl_wr.data = decrypt ? fill_n_ff : cand;

endmodule
`default_nettype wire

// ===== tb/ksc_checker.sv =====
// Checker for the keyword substitution cipher: predicts each output word and compares it.
`default_nettype none
module ksc_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [7:0]  rsp_out_byte,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_wdata,
   output int               mismatches,
   output int               pending_words
);

   logic [63:0] key_chars;
   logic [3:0]  key_len;
   logic        decrypt;
   logic [7:0]  expected_bytes[$];

   // Letter number 0..25 of an ASCII letter, or -1 for any other byte.
   function automatic int alpha_index(input logic [7:0] c);
      if (c >= ksc_pkg::CH_UPPER_A && c <= ksc_pkg::CH_UPPER_Z)
         return int'(c - ksc_pkg::CH_UPPER_A);
      if (c >= ksc_pkg::CH_LOWER_A && c <= ksc_pkg::CH_LOWER_Z)
         return int'(c - ksc_pkg::CH_LOWER_A);
      return -1;
   endfunction

   function automatic logic [7:0] cipher_byte(input logic [7:0] b);
      logic [4:0]  alpha [0:25];
      logic [25:0] taken;
      logic [4:0]  m;
      int          n;
      int          klen;
      int          li;
      int          i;
      taken = '0;
      n     = 0;
      m     = '0;
      klen  = (key_len > 4'd8) ? 8 : int'(key_len);
      for (i = 0; i < 26; i++) alpha[i] = '0;
      for (i = 0; i < klen; i++) begin
         li = alpha_index(key_chars[8*i +: 8]);
         if (li >= 0 && !taken[li]) begin
            taken[li] = 1'b1;
            alpha[n]  = 5'(li);
            n++;
         end
      end
      // Letters the keyword left out follow in reverse order, Z first.
      for (i = 25; i >= 0; i--) begin
         if (!taken[i]) begin
            alpha[n] = 5'(i);
            n++;
         end
      end
      li = alpha_index(b);
      if (li < 0) return b;
      if (!decrypt) begin
         m = alpha[li];
      end else begin
         for (i = 0; i < 26; i++) begin
            if (alpha[i] == 5'(li)) m = 5'(i);
         end
      end
      return ((b >= ksc_pkg::CH_LOWER_A) ? ksc_pkg::CH_LOWER_A : ksc_pkg::CH_UPPER_A)
             + {3'b000, m};
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         key_chars  = ksc_pkg::KEY_RESET;
         key_len    = ksc_pkg::LEN_RESET;
         decrypt    = 1'b0;
         mismatches = 0;
         expected_bytes.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               ksc_pkg::CSR_KEYWORD: key_chars = csr_wdata;
               ksc_pkg::CSR_LENGTH:  key_len   = csr_wdata[3:0];
               ksc_pkg::CSR_MODE:    decrypt   = csr_wdata[0];
               default:              ;
            endcase
         end
         if (req_valid && !req_stall) expected_bytes.push_back(cipher_byte(req_data_byte));
         if (rsp_valid && !rsp_stall) begin
            if (expected_bytes.size() == 0) begin
               $error("out_byte: no expected word waiting, got %h", rsp_out_byte);
               mismatches++;
            end else begin
               if (rsp_out_byte !== expected_bytes[0]) begin
                  $error("out_byte mismatch: expected %h, got %h",
                         expected_bytes[0], rsp_out_byte);
                  mismatches++;
               end
               void'(expected_bytes.pop_front());
            end
         end
      end
      pending_words = expected_bytes.size();
   end

endmodule
`default_nettype wire

// ===== tb/keyword_substitution_cipher_tb.sv =====
// Testbench top for the keyword substitution cipher: stimulus, idling and the verdict.
`default_nettype none
module keyword_substitution_cipher_tb;

   localparam logic [1:0] CSR_UNUSED = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic [7:0]  req_data_byte = '0;
   logic        rsp_stall = 1'b0;
   logic        csr_valid = 1'b0;
   logic [1:0]  csr_index = ksc_pkg::CSR_KEYWORD;
   logic [63:0] csr_wdata = '0;
   wire logic       req_stall;
   wire logic       rsp_valid;
   wire logic [7:0] rsp_out_byte;
   wire logic       csr_ready;
   int mismatches;
   int pending_words;

   int send_idle_pct = 0;
   int stall_pct     = 0;

   // Field extremes, the ends of both letter ranges, the bytes just outside them, and 80, 4D, 6D.
   logic [7:0] edge_bytes [0:12] = '{8'h00, 8'hFF, 8'h41, 8'h5A, 8'h61, 8'h7A, 8'h40,
                                     8'h5B, 8'h60, 8'h7B, 8'h80, 8'h4D, 8'h6D};

   keyword_substitution_cipher uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_out_byte(rsp_out_byte),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   ksc_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_out_byte(rsp_out_byte),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata),
      .mismatches(mismatches), .pending_words(pending_words)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // Returns at the edge that accepted the word, with nothing driven yet in that step.
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain_results;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly letters of either case, so the table is exercised, with some arbitrary bytes.
   function automatic logic [7:0] random_text_byte();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 3) return ksc_pkg::CH_UPPER_A + 8'($urandom_range(0, 25));
      if (pick < 6) return ksc_pkg::CH_LOWER_A + 8'($urandom_range(0, 25));
      return 8'($urandom_range(0, 255));
   endfunction

   initial begin : stimulus
      logic [63:0] key_word;
      logic [63:0] len_word;
      logic [63:0] mode_word;
      int          phase;
      int          k;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset keyword, encrypt.
      foreach (edge_bytes[i]) send_byte(edge_bytes[i]);
      drain_results();

      // Reset keyword, decrypt.
      write_reg(ksc_pkg::CSR_MODE, 64'd1);
      send_byte(8'h41);
      send_byte(8'h5A);
      send_byte(8'h61);
      send_byte(8'h7A);
      send_byte(8'h46);
      drain_results();

      // Repeats, a digit, a high byte, and a length past the eight-byte limit.
      write_reg(ksc_pkg::CSR_KEYWORD, 64'h5171_5A7A_8041_3161);
      write_reg(ksc_pkg::CSR_LENGTH, 64'd15);
      write_reg(ksc_pkg::CSR_MODE, 64'd0);
      send_byte(8'h41);
      send_byte(8'h7A);
      send_byte(8'h51);
      drain_results();

      // A write to the unused index must leave the table as it is.
      write_reg(CSR_UNUSED, {$urandom, $urandom});
      send_byte(8'h61);
      send_byte(8'h4E);

      for (phase = 0; phase < 12; phase++) begin
         drain_results();
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 81; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 81; end
            default: begin send_idle_pct = 6; stall_pct = 6; end
         endcase
         for (k = 0; k < 8; k++) key_word[8*k +: 8] = random_text_byte();
         len_word  = {$urandom, $urandom};
         mode_word = {$urandom, $urandom};
         case (phase)
            0: begin key_word = '0;  len_word[3:0] = 4'd8;  end
            1: begin key_word = '1;  len_word[3:0] = 4'd15; end
            2: len_word[3:0] = 4'd0;
            3: len_word[3:0] = 4'd1;
            4: len_word[3:0] = 4'd8;
            default: len_word[3:0] = ($urandom_range(0, 1) != 0) ?
                                     4'($urandom_range(5, 8)) : 4'($urandom_range(0, 15));
         endcase
         mode_word[0] = phase[0];
         write_reg(ksc_pkg::CSR_KEYWORD, key_word);
         write_reg(ksc_pkg::CSR_LENGTH, len_word);
         write_reg(ksc_pkg::CSR_MODE, mode_word);
         if (phase == 6) write_reg(CSR_UNUSED, {$urandom, $urandom});
         for (k = 0; k < 40; k++) send_byte(random_text_byte());
      end

      drain_results();
      repeat (4) @(posedge clock);
      if (mismatches == 0 && pending_words == 0) begin
         $display("Simulation PASSED");
      end else begin
         if (pending_words != 0) $error("out_byte: %0d expected words never arrived", pending_words);
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #2000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
`default_nettype wire
